// ===== hw/rtl/tkh_pkg.sv =====
// Shared types and codes for the top-k min-heap tracker.
// No dependencies; used by tkh_ctrl, tkh_dp and the top level.
`default_nettype none
package tkh_pkg;

  localparam logic [2:0] ACT_RAISED    = 3'd0;
  localparam logic [2:0] ACT_UNCHANGED = 3'd1;
  localparam logic [2:0] ACT_INSERTED  = 3'd2;
  localparam logic [2:0] ACT_REPLACED  = 3'd3;
  localparam logic [2:0] ACT_REJECTED  = 3'd4;

  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LOAD      = 4'd1;
  localparam logic [3:0] CMD_STEP      = 4'd2;
  localparam logic [3:0] CMD_RAISE     = 4'd3;
  localparam logic [3:0] CMD_INSERT    = 4'd4;
  localparam logic [3:0] CMD_REPLACE   = 4'd5;
  localparam logic [3:0] CMD_SWAP_UP   = 4'd6;
  localparam logic [3:0] CMD_SWAP_DOWN = 4'd7;
  localparam logic [3:0] CMD_RESULT    = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] act;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic hit;
    logic search_end;
    logic higher;
    logic room;
    logic beats_min;
    logic up_ok;
    logic down_ok;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tkh_ctrl.sv =====
// Sequencer for the tracker: key search, placement and heap sift steps.
// Depends on tkh_pkg; drives tkh_dp through cmd_t and reads status_t.
`default_nettype none
module tkh_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  tkh_pkg::status_t st,
  output tkh_pkg::cmd_t    cmd
);
  import tkh_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UP     = 2'd2;
  localparam logic [1:0] S_DOWN   = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] act, act_next;

  assign s_tready = (state == S_IDLE) && !st.out_busy;

  always_comb begin
    state_next = state;
    act_next   = act;
    cmd.op     = CMD_NONE;
    cmd.act    = act;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.op     = CMD_LOAD;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        priority if (st.hit) begin
          if (st.higher) begin
            cmd.op = CMD_RAISE; act_next = ACT_RAISED; state_next = S_DOWN;
          end else begin
            cmd.op = CMD_RESULT; cmd.act = ACT_UNCHANGED; state_next = S_IDLE;
          end
        end else if (st.search_end) begin
          priority if (st.room) begin
            cmd.op = CMD_INSERT; act_next = ACT_INSERTED; state_next = S_UP;
          end else if (st.beats_min) begin
            cmd.op = CMD_REPLACE; act_next = ACT_REPLACED; state_next = S_DOWN;
          end else begin
            cmd.op = CMD_RESULT; cmd.act = ACT_REJECTED; state_next = S_IDLE;
          end
        end else begin
          cmd.op = CMD_STEP;
        end
      end
      S_UP: begin
        if (st.up_ok) begin
          cmd.op = CMD_SWAP_UP;
        end else begin
          cmd.op = CMD_RESULT; state_next = S_IDLE;
        end
      end
      S_DOWN: begin
        if (st.down_ok) begin
          cmd.op = CMD_SWAP_DOWN;
        end else begin
          cmd.op = CMD_RESULT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_REJECTED;
    end else begin
      state <= state_next;
      act   <= act_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tkh_dp.sv =====
// Datapath for the tracker: heap entry registers, cursor, count, result register.
// Depends on tkh_pkg; commanded by tkh_ctrl.
`default_nettype none
module tkh_dp #(
  parameter int CAPACITY = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire  [95:0]      s_tdata,
  input  tkh_pkg::cmd_t    cmd,
  output tkh_pkg::status_t st,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [39:0]      m_tdata
);
  import tkh_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

  logic [31:0]        keys   [CAPACITY];
  logic signed [31:0] scores [CAPACITY];
  logic [30:0]        ids    [CAPACITY];

  logic [CW-1:0]      count;
  logic [CW-1:0]      pos;
  logic [31:0]        in_key;
  logic signed [31:0] in_score;
  logic [30:0]        in_id;

  logic [CW:0]        pos_w, lft, rgt, par, best;
  logic signed [31:0] s_pos, s_l, s_r, s_best, s_par;
  logic [AW-1:0]      a_pos, a_best, a_par;

  always_comb begin
    pos_w  = {1'b0, pos};
    lft    = (pos_w << 1) + (CW + 1)'(1);
    rgt    = (pos_w << 1) + (CW + 1)'(2);
    par    = (pos_w - (CW + 1)'(1)) >> 1;
    a_pos  = pos[AW-1:0];
    a_par  = par[AW-1:0];
    s_pos  = scores[a_pos];
    s_l    = scores[lft[AW-1:0]];
    s_r    = scores[rgt[AW-1:0]];
    s_par  = scores[a_par];
    best   = pos_w;
    s_best = s_pos;
    if (lft < {1'b0, count} && s_l < s_best) begin
      best = lft; s_best = s_l;
    end
    if (rgt < {1'b0, count} && s_r < s_best) begin
      best = rgt;
    end
    a_best = best[AW-1:0];

    st.out_busy   = m_tvalid;
    st.search_end = pos >= count;
    st.hit        = !st.search_end && (keys[a_pos] == in_key);
    st.higher     = in_score > s_pos;
    st.room       = {1'b0, count} < CAP_W;
    st.beats_min  = in_score > scores[0];
    st.up_ok      = (pos != '0) && (s_par > s_pos);
    st.down_ok    = best != pos_w;
  end

  // Entry storage and cursor.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        in_key   <= s_tdata[31:0];
        in_score <= s_tdata[63:32];
        in_id    <= s_tdata[94:64];
        pos      <= '0;
      end
      CMD_STEP: pos <= pos + CW'(1);
      CMD_RAISE: scores[a_pos] <= in_score;
      CMD_INSERT: begin
        keys[count[AW-1:0]]   <= in_key;
        scores[count[AW-1:0]] <= in_score;
        ids[count[AW-1:0]]    <= in_id;
        pos                   <= count;
      end
      CMD_REPLACE: begin
        keys[0]   <= in_key;
        scores[0] <= in_score;
        ids[0]    <= in_id;
        pos       <= '0;
      end
      CMD_SWAP_UP: begin
        keys[a_pos]   <= keys[a_par];   keys[a_par]   <= keys[a_pos];
        scores[a_pos] <= s_par;         scores[a_par] <= s_pos;
        ids[a_pos]    <= ids[a_par];    ids[a_par]    <= ids[a_pos];
        pos           <= par[CW-1:0];
      end
      CMD_SWAP_DOWN: begin
        keys[a_pos]    <= keys[a_best];   keys[a_best]   <= keys[a_pos];
        scores[a_pos]  <= scores[a_best]; scores[a_best] <= s_pos;
        ids[a_pos]     <= ids[a_best];    ids[a_best]    <= ids[a_pos];
        pos            <= best[CW-1:0];
      end
      default: ;
    endcase
  end

  // Count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.op == CMD_INSERT) count <= count + CW'(1);
      if (cmd.op == CMD_RESULT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_RESULT) begin
      m_tdata[2:0]   <= cmd.act;
      m_tdata[34:3]  <= (count != '0) ? scores[0] : 32'sd0;
      m_tdata[39:35] <= 5'(count);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/top_k_min_heap_tracker_unit.sv =====
// Top-k min-heap tracker: keeps the CAPACITY best-scoring keyed entries.
// Uses tkh_pkg, tkh_ctrl (sequencer) and tkh_dp (heap storage and compare).
//
// Usage:
//   Offer items on the s_ stream: a player key, a signed score and an id.
//   Each item yields exactly one result item on the m_ stream: the action
//   taken, the lowest held score after the step (0 when empty) and the
//   number of held entries.
// Processing:
//   One item at a time. The key search walks the held entries one per cycle
//   and decides on a miss once the walk has passed the last entry, then the
//   heap is restored one compare-swap per cycle (sifting up after an insert,
//   down after a raise or replace), then the result register is loaded.
//   The search loop over the entry registers is the longest phase.
// Reset:
//   rst (synchronous, active high) empties the table and drops any pending
//   result; entry contents are left as they are and never read until written.
// Stalls:
//   A result waits in the output register while m_tready is low; the next
//   item is not taken until that result has gone.
`default_nettype none
module top_k_min_heap_tracker_unit #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [95:0] s_tdata,   // player_key[31:0], score[63:32], player_id[94:64], pad
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata    // action[2:0], min_score[34:3], entry_count[39:35]
);
  import tkh_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer: search, place, sift, report.
  tkh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Heap entries, cursor and result register.
  tkh_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );
endmodule
`default_nettype wire
